/* rtl/core/atapd_pkg.sv */
// types, constants and helper functions for the packet drive task-file block
// used by ata_packet_drive_registers; no dependencies
package atapd_pkg;

  localparam int NUM_REGS       = 9;
  localparam int SLOT_W         = 4;
  localparam int COUNT_W        = 6;
  localparam int PACKET_BYTES_D = 12;

  localparam logic [31:0] CMD_PACKET = 32'h0000_00a0;

  // slot order of the decoded task-file registers
  localparam logic [SLOT_W-1:0] SLOT_DRIVE_SEL = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_ALT       = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_STATUS    = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_DATA      = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_ERROR     = 4'd4;

  localparam logic [23:0] REG_ADDR [NUM_REGS] = '{
    24'h5f7098, 24'h5f7018, 24'h5f709c, 24'h5f7080, 24'h5f7084,
    24'h5f7088, 24'h5f708c, 24'h5f7090, 24'h5f7094
  };

  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_BAD_ADDR = 2'd1,
    RC_BAD_LEN  = 2'd2
  } result_code_t;

  typedef struct packed {
    logic        func;
    logic [23:0] address;
    logic [3:0]  access_bytes;
    logic [31:0] write_data;
    logic        busy_set;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  result_code;
    logic        irq_pending;
  } rsp_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } decode_t;

  // parallel compare against the nine task-file addresses
  function automatic decode_t decode_addr(input logic [23:0] addr);
    decode_t d;
    d.hit  = 1'b0;
    d.slot = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (REG_ADDR[i] == addr) begin
        d.hit  = 1'b1;
        d.slot = SLOT_W'(i);
      end
    end
    return d;
  endfunction

  // mask of the low n bytes, full word for four or more
  function automatic logic [31:0] byte_mask(input logic [3:0] n);
    logic [31:0] m;
    case (n)
      4'd0:    m = 32'h0000_0000;
      4'd1:    m = 32'h0000_00ff;
      4'd2:    m = 32'h0000_ffff;
      4'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/ata_packet_drive_registers.sv */
// packet drive task-file register block: decode, status flags, packet byte count
// depends on atapd_pkg
//
// Usage: one bus access per req transfer (read or write, 24-bit address,
// length 1..8 bytes). Each access yields exactly one rsp transfer with the
// masked read data, a result code (ok, unknown address, length above four)
// and the interrupt level after the access.
// Timing: the access is captured in an input register, then decoded and
// applied to the register state in one pass that loads the response
// register, which drives rsp_valid and rsp.
// Throughput: one access per cycle while rsp is taken; each access updates
// the state as its response loads, so the next access sees it right away.
// Stall: when rsp is not taken, the response register holds, the input
// register fills and req_ready drops; nothing is lost or repeated.
// Reset: clears valid flags, plain registers, busy, data request, interrupt
// and the packet byte count. No initialization sweep is needed.
module ata_packet_drive_registers #(
  parameter int PACKET_BYTES = atapd_pkg::PACKET_BYTES_D
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  atapd_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output atapd_pkg::rsp_t  rsp
);
  import atapd_pkg::*;

  localparam logic [COUNT_W-1:0] PKT_END = COUNT_W'(PACKET_BYTES);

  // input register
  logic s1_valid;
  req_t s1;
  logic s2_take;

  // register state
  logic [31:0]        plain_words [NUM_REGS];
  logic               busy_flag;
  logic               data_request_flag;
  logic               interrupt_flag;
  logic [COUNT_W-1:0] packet_count;

  logic               busy_next;
  logic               data_request_next;
  logic               interrupt_next;
  logic [COUNT_W-1:0] packet_count_next;
  logic               word_we;
  logic [31:0]        word_next;
  rsp_t               rsp_next;

  decode_t            dec;
  logic [31:0]        mask;
  logic [31:0]        status_word;
  logic [COUNT_W-1:0] count_inc;

  assign s2_take   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s2_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      s1 <= req;
    end
  end

  always_comb begin
    dec         = decode_addr(s1.address);
    mask        = byte_mask(s1.access_bytes);
    count_inc   = packet_count + COUNT_W'(2);

    busy_next         = busy_flag | s1.busy_set;
    data_request_next = data_request_flag;
    interrupt_next    = interrupt_flag;
    packet_count_next = packet_count;
    word_we           = 1'b0;
    word_next         = (plain_words[dec.slot] & ~mask) | (s1.write_data & mask);
    // status reflects busy after the busy input is applied
    status_word       = {24'd0, busy_next, 3'd0, data_request_flag, 3'd0};

    rsp_next.read_data   = '0;
    rsp_next.result_code = RC_OK;

    if (!dec.hit) begin
      rsp_next.result_code = RC_BAD_ADDR;
    end else if (s1.access_bytes > 4'd4) begin
      rsp_next.result_code = RC_BAD_LEN;
    end else if (!s1.func) begin
      case (dec.slot)
        SLOT_STATUS: begin
          rsp_next.read_data = status_word & mask;
          interrupt_next     = 1'b0;
        end
        SLOT_ALT:   rsp_next.read_data = status_word & mask;
        SLOT_ERROR: rsp_next.read_data = '0;
        default:    rsp_next.read_data = plain_words[dec.slot] & mask;
      endcase
    end else begin
      case (dec.slot)
        SLOT_STATUS: begin
          if ((s1.write_data & mask) == CMD_PACKET) begin
            data_request_next = 1'b1;
          end
          interrupt_next = 1'b1;
        end
        SLOT_DATA: begin
          if (count_inc >= PKT_END) begin
            packet_count_next = '0;
            data_request_next = 1'b0;
            busy_next         = 1'b0;
            interrupt_next    = 1'b1;
          end else begin
            packet_count_next = count_inc;
          end
        end
        default: word_we = 1'b1;
      endcase
    end

    rsp_next.irq_pending = interrupt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid         <= 1'b0;
      busy_flag         <= 1'b0;
      data_request_flag <= 1'b0;
      interrupt_flag    <= 1'b0;
      packet_count      <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        plain_words[i] <= '0;
      end
    end else begin
      if (s2_take) begin
        rsp_valid         <= 1'b1;
        busy_flag         <= busy_next;
        data_request_flag <= data_request_next;
        interrupt_flag    <= interrupt_next;
        packet_count      <= packet_count_next;
        if (word_we) begin
          plain_words[dec.slot] <= word_next;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (s2_take) begin
      rsp <= rsp_next;
    end
  end

  // the packet count only moves in steps of two and wraps before the end value
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    packet_count < PKT_END && packet_count[0] == 1'b0)
    else $error("packet byte count out of range");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_code != RC_OK |-> rsp.read_data == 32'd0)
    else $error("error response carries read data");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.result_code != 2'd3)
    else $error("illegal result code");

  // a held access in the input register must not change while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_take |=> s1_valid && $stable(s1))
    else $error("input register lost a pending access");

  a_status_read_clears: assert property (@(posedge clk) disable iff (rst)
    s2_take && dec.hit && !s1.func && dec.slot == SLOT_STATUS
      && s1.access_bytes <= 4'd4 |=> !interrupt_flag && !rsp.irq_pending)
    else $error("status read did not clear the interrupt");

endmodule
